### rtl/envelope_follower_knee_amount_macros.svh
// assertion macros used by the checker of this block
`ifndef ENVELOPE_FOLLOWER_KNEE_AMOUNT_MACROS_SVH
`define ENVELOPE_FOLLOWER_KNEE_AMOUNT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define EFKA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define EFKA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/efka_pkg.sv
package efka_pkg;

   localparam int ENV_W      = 32;
   localparam int COEF_W     = 24;
   localparam int GAIN_W     = 24;
   localparam int MUL_W      = 32;
   localparam int PROD_W     = 64;
   localparam int SPAN_W     = 34;
   localparam int KNEE_W     = 26;
   localparam int STEP_W     = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // 2.98107 in Q2.24, i.e. 10^(12/20) - 1
   localparam logic [KNEE_W-1:0] KNEE_Q24 = 26'd50014084;
   localparam logic [COEF_W:0]   COEF_ONE = 25'h1000000;

   localparam logic [ENV_W-1:0]  THRESHOLD_RESET = 32'd8388608;
   localparam logic [GAIN_W-1:0] GAIN_RESET      = 24'd262144;
   localparam logic [COEF_W-1:0] COEF_RESET      = 24'd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_GAIN      = 2'd1,
      CSR_ATTACK    = 2'd2,
      CSR_RELEASE   = 2'd3
   } efka_csr_type;

   typedef enum logic [1:0] {
      A_MAG   = 2'd0,
      A_LEVEL = 2'd1,
      A_ENV   = 2'd2,
      A_THR   = 2'd3
   } efka_a_sel_type;

   typedef enum logic [1:0] {
      B_GAIN     = 2'd0,
      B_COEF_INV = 2'd1,
      B_COEF     = 2'd2,
      B_KNEE     = 2'd3
   } efka_b_sel_type;

   typedef enum logic [3:0] {
      OP_NONE   = 4'd0,
      OP_ABS    = 4'd1,
      OP_LEVEL  = 4'd2,
      OP_COEF   = 4'd3,
      OP_ACC    = 4'd4,
      OP_ENV    = 4'd5,
      OP_SPAN   = 4'd6,
      OP_DECIDE = 4'd7,
      OP_DIV    = 4'd8
   } efka_op_type;

   typedef enum logic [1:0] {
      SEQ_NEXT   = 2'd0,
      SEQ_LOOP   = 2'd1,
      SEQ_BRANCH = 2'd2,
      SEQ_END    = 2'd3
   } efka_seq_type;

   typedef struct packed {
      efka_a_sel_type    a_sel;
      efka_b_sel_type    b_sel;
      logic              mul_en;
      efka_op_type       op;
      efka_seq_type      seq;
      logic [STEP_W-1:0] target;
   } efka_word_type;

   typedef struct packed {
      efka_word_type word;
      logic          capture;
      logic          deliver;
   } efka_ctl_type;

   typedef struct packed {
      logic trivial;
      logic div_last;
   } efka_status_type;

   localparam logic [STEP_W-1:0] STEP_DIV = 4'd10;
   localparam logic [STEP_W-1:0] STEP_END = 4'd11;

   // control store: one word per step
   function automatic efka_word_type microcode(input logic [STEP_W-1:0] step);
      efka_word_type w;
      w = '{a_sel: A_MAG, b_sel: B_GAIN, mul_en: 1'b0, op: OP_NONE,
            seq: SEQ_NEXT, target: STEP_END};
      unique case (step)
         4'd0:  w.op = OP_ABS;
         4'd1:  w.mul_en = 1'b1;
         4'd2:  w.op = OP_LEVEL;
         4'd3:  w.op = OP_COEF;
         4'd4:  begin
            w.a_sel  = A_LEVEL;
            w.b_sel  = B_COEF_INV;
            w.mul_en = 1'b1;
         end
         4'd5:  begin
            w.a_sel  = A_ENV;
            w.b_sel  = B_COEF;
            w.mul_en = 1'b1;
            w.op     = OP_ACC;
         end
         4'd6:  w.op = OP_ENV;
         4'd7:  begin
            w.a_sel  = A_THR;
            w.b_sel  = B_KNEE;
            w.mul_en = 1'b1;
         end
         4'd8:  w.op = OP_SPAN;
         4'd9:  begin
            w.op     = OP_DECIDE;
            w.seq    = SEQ_BRANCH;
            w.target = STEP_END;
         end
         STEP_DIV: begin
            w.op  = OP_DIV;
            w.seq = SEQ_LOOP;
         end
         default: w.seq = SEQ_END;
      endcase
      return w;
   endfunction

endpackage

### rtl/efka_req_if.sv
interface efka_req_if #(
   parameter int WIDTH = 24
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] difference;

   modport source (output valid, output difference, input ready);
   modport sink   (input valid, input difference, output ready);
endinterface

### rtl/efka_rsp_if.sv
interface efka_rsp_if #(
   parameter int WIDTH = 17
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] amount;

   modport source (output valid, output amount, input ready);
   modport sink   (input valid, input amount, output ready);
endinterface

### rtl/efka_sequencer.sv
module efka_sequencer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   input  efka_pkg::efka_status_type status,
   output efka_pkg::efka_ctl_type    ctl
);
   import efka_pkg::*;

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   efka_word_type     word;
   logic              accept;
   logic              deliver;

   assign word      = microcode(step_ff);
   assign req_ready = !busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && !busy_ff;
   assign deliver   = busy_ff && (word.seq == SEQ_END) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      ctl.word        = word;
      ctl.word.mul_en = word.mul_en && busy_ff;
      ctl.word.op     = busy_ff ? word.op : OP_NONE;
      ctl.capture     = accept;
      ctl.deliver     = deliver;
   end

   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (!busy_ff) begin
         if (accept) begin
            busy_in = 1'b1;
            step_in = '0;
         end
      end else begin
         unique case (word.seq)
            SEQ_NEXT:   step_in = step_ff + 1'b1;
            SEQ_LOOP:   step_in = status.div_last ? step_ff + 1'b1 : step_ff;
            SEQ_BRANCH: step_in = status.trivial ? word.target : step_ff + 1'b1;
            SEQ_END: begin
               if (deliver) begin
                  busy_in      = 1'b0;
                  step_in      = '0;
                  rsp_valid_in = 1'b1;
               end
            end
            default: step_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/efka_datapath.sv
module efka_datapath #(
   parameter int SAMPLE_WIDTH     = 24,
   parameter int AMOUNT_FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [SAMPLE_WIDTH-1:0]              difference,
   input  efka_pkg::efka_ctl_type               ctl,
   input  logic                                 csr_write_enable,
   input  logic [efka_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [efka_pkg::CSR_DATA_W-1:0]      csr_write_data,
   output efka_pkg::efka_status_type            status,
   output logic [AMOUNT_FRAC_BITS:0]            amount
);
   import efka_pkg::*;

   localparam int SAMPLE_FRAC = SAMPLE_WIDTH - 4;
   localparam int LEVEL_SHIFT = SAMPLE_WIDTH - 9;
   localparam int AMOUNT_W    = AMOUNT_FRAC_BITS + 1;
   localparam int CNT_W       = $clog2(AMOUNT_FRAC_BITS);
   // smallest magnitude that is not below 1e-5
   localparam logic [SAMPLE_WIDTH-1:0] SILENCE_LIMIT =
      SAMPLE_WIDTH'(((64'd1 << SAMPLE_FRAC) + 64'd99999) / 64'd100000);
   localparam logic [AMOUNT_W-1:0] AMOUNT_FULL = AMOUNT_W'(1) << AMOUNT_FRAC_BITS;
   localparam logic [CNT_W-1:0]    CNT_LAST    = CNT_W'(AMOUNT_FRAC_BITS - 1);

   // configuration
   logic [ENV_W-1:0]  thr_ff, thr_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic [COEF_W-1:0] attack_ff, attack_in;
   logic [COEF_W-1:0] release_ff, release_in;

   // working registers
   logic [SAMPLE_WIDTH-1:0]     diff_ff, diff_in;
   logic [SAMPLE_WIDTH-1:0]     mag_ff, mag_in;
   logic [PROD_W-1:0]           prod_ff, prod_in;
   logic [PROD_W-1:0]           acc_ff, acc_in;
   logic [ENV_W-1:0]            level_ff, level_in;
   logic [COEF_W-1:0]           coef_ff, coef_in;
   logic [ENV_W-1:0]            env_ff, env_in;
   logic [SPAN_W-1:0]           span_ff, span_in;
   logic [ENV_W-1:0]            over_ff, over_in;
   logic [SPAN_W-1:0]           rem_ff, rem_in;
   logic [AMOUNT_FRAC_BITS-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [AMOUNT_W-1:0]         work_ff, work_in;
   logic [AMOUNT_W-1:0]         amount_ff, amount_in;

   logic [MUL_W-1:0]    a_op, b_op;
   logic [PROD_W-1:0]   mul_result;
   logic [PROD_W-1:0]   level_shifted;
   logic [PROD_W-1:0]   mix_sum;
   logic                silent;
   logic                not_above;
   logic                saturate;
   logic [SPAN_W:0]     rem_shifted;
   logic [SPAN_W:0]     rem_less;
   logic                rem_ge;
   logic [COEF_W:0]     coef_inv;

   always_comb begin
      case (ctl.word.a_sel)
         A_MAG:   a_op = MUL_W'(mag_ff);
         A_LEVEL: a_op = level_ff;
         A_ENV:   a_op = env_ff;
         A_THR:   a_op = thr_ff;
         default: a_op = '0;
      endcase
   end

   assign coef_inv = COEF_ONE - {1'b0, coef_ff};

   always_comb begin
      case (ctl.word.b_sel)
         B_GAIN:     b_op = MUL_W'(gain_ff);
         B_COEF_INV: b_op = MUL_W'(coef_inv);
         B_COEF:     b_op = MUL_W'(coef_ff);
         B_KNEE:     b_op = MUL_W'(KNEE_Q24);
         default:    b_op = '0;
      endcase
   end

   assign mul_result    = {{(PROD_W-MUL_W){1'b0}}, a_op} * {{(PROD_W-MUL_W){1'b0}}, b_op};
   assign level_shifted = prod_ff >> LEVEL_SHIFT;
   assign silent        = mag_ff < SILENCE_LIMIT;
   assign mix_sum       = acc_ff + prod_ff;
   assign not_above     = env_ff <= thr_ff;
   assign saturate      = (span_ff == '0) || ({{(SPAN_W-ENV_W){1'b0}}, over_ff} >= span_ff);
   assign rem_shifted   = {rem_ff, 1'b0};
   assign rem_less      = rem_shifted - {1'b0, span_ff};
   assign rem_ge        = rem_shifted >= {1'b0, span_ff};

   assign status.trivial  = not_above || saturate;
   assign status.div_last = cnt_ff == CNT_LAST;
   assign amount          = amount_ff;

   always_comb begin
      thr_in     = thr_ff;
      gain_in    = gain_ff;
      attack_in  = attack_ff;
      release_in = release_ff;
      if (csr_write_enable) begin
         case (efka_csr_type'(csr_index))
            CSR_THRESHOLD: thr_in     = csr_write_data[ENV_W-1:0];
            CSR_GAIN:      gain_in    = csr_write_data[GAIN_W-1:0];
            CSR_ATTACK:    attack_in  = csr_write_data[COEF_W-1:0];
            CSR_RELEASE:   release_in = csr_write_data[COEF_W-1:0];
            default:       ;
         endcase
      end
   end

   always_comb begin
      diff_in   = ctl.capture ? difference : diff_ff;
      mag_in    = mag_ff;
      prod_in   = ctl.word.mul_en ? mul_result : prod_ff;
      acc_in    = acc_ff;
      level_in  = level_ff;
      coef_in   = coef_ff;
      env_in    = env_ff;
      span_in   = span_ff;
      over_in   = over_ff;
      rem_in    = rem_ff;
      quot_in   = quot_ff;
      cnt_in    = cnt_ff;
      work_in   = work_ff;
      amount_in = ctl.deliver ? work_ff : amount_ff;
      unique case (ctl.word.op)
         OP_NONE: ;
         OP_ABS: mag_in = diff_ff[SAMPLE_WIDTH-1] ? (~diff_ff + 1'b1) : diff_ff;
         OP_LEVEL: begin
            if (silent) begin
               level_in = '0;
            end else if (|level_shifted[PROD_W-1:ENV_W]) begin
               level_in = '1;
            end else begin
               level_in = level_shifted[ENV_W-1:0];
            end
         end
         OP_COEF: coef_in = (level_ff > env_ff) ? attack_ff : release_ff;
         OP_ACC:  acc_in  = prod_ff;
         OP_ENV:  env_in  = mix_sum[COEF_W +: ENV_W];
         OP_SPAN: begin
            span_in = prod_ff[COEF_W +: SPAN_W];
            over_in = env_ff - thr_ff;
         end
         OP_DECIDE: begin
            rem_in  = {{(SPAN_W-ENV_W){1'b0}}, over_ff};
            quot_in = '0;
            cnt_in  = '0;
            if (not_above) begin
               work_in = '0;
            end else if (saturate) begin
               work_in = AMOUNT_FULL;
            end
         end
         OP_DIV: begin
            rem_in  = rem_ge ? rem_less[SPAN_W-1:0] : rem_shifted[SPAN_W-1:0];
            quot_in = {quot_ff[AMOUNT_FRAC_BITS-2:0], rem_ge};
            cnt_in  = cnt_ff + 1'b1;
            work_in = {1'b0, quot_ff[AMOUNT_FRAC_BITS-2:0], rem_ge};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff     <= THRESHOLD_RESET;
         gain_ff    <= GAIN_RESET;
         attack_ff  <= COEF_RESET;
         release_ff <= COEF_RESET;
         env_ff     <= '0;
         cnt_ff     <= '0;
      end else begin
         thr_ff     <= thr_in;
         gain_ff    <= gain_in;
         attack_ff  <= attack_in;
         release_ff <= release_in;
         env_ff     <= env_in;
         cnt_ff     <= cnt_in;
      end
      diff_ff   <= diff_in;
      mag_ff    <= mag_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      level_ff  <= level_in;
      coef_ff   <= coef_in;
      span_ff   <= span_in;
      over_ff   <= over_in;
      rem_ff    <= rem_in;
      quot_ff   <= quot_in;
      work_ff   <= work_in;
      amount_ff <= amount_in;
   end

endmodule

### rtl/envelope_follower_knee_amount.sv
// channel   role     handshake          payload
// req_chan  sink     valid/ready        difference, SAMPLE_WIDTH bit signed Q3
// rsp_chan  source   valid/ready        amount, AMOUNT_FRAC_BITS+1 bit unsigned
// csr       write    csr_write_enable   csr_index (2 bit), csr_write_data (32 bit)
//
// an item is worked one at a time by a microcoded sequencer: a read-only control
// store steps a datapath built round one shared 32x32 multiplier (four products per
// item) and a restoring divider that yields one quotient bit per cycle
// an item runs the divider for every quotient bit, but skips it when the envelope
// is at or below threshold or the amount is at full scale;
// req_chan.ready returns in the same cycle as the result is loaded
// the result sits in an output register, so a stalled rsp_chan only holds the
// sequencer at its last step once a second result is ready
// reset is synchronous and active high: configuration returns to its defaults and
// the envelope to zero
module envelope_follower_knee_amount #(
   parameter int SAMPLE_WIDTH     = 24,
   parameter int AMOUNT_FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   efka_req_if.sink                          req_chan,
   efka_rsp_if.source                        rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [efka_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [efka_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import efka_pkg::*;

   // control word and status between the sequencer and the datapath
   efka_ctl_type    ctl;
   efka_status_type status;

   // step counter, control store and handshakes
   efka_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .status    (status),
      .ctl       (ctl)
   );

   // magnitude, level, follower, knee span and divider, plus the registers
   efka_datapath #(
      .SAMPLE_WIDTH     (SAMPLE_WIDTH),
      .AMOUNT_FRAC_BITS (AMOUNT_FRAC_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .difference       (req_chan.difference),
      .ctl              (ctl),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .status           (status),
      .amount           (rsp_chan.amount)
   );

endmodule

### rtl/efka_checker.sv
`include "envelope_follower_knee_amount_macros.svh"

module efka_checker #(
   parameter int AMOUNT_FRAC_BITS = 16
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [AMOUNT_FRAC_BITS:0] rsp_amount
);
   localparam int AMOUNT_W = AMOUNT_FRAC_BITS + 1;
   localparam logic [AMOUNT_W-1:0] AMOUNT_FULL = AMOUNT_W'(1) << AMOUNT_FRAC_BITS;

   `EFKA_ASSERT_NOW(a_amount_range, rsp_valid, rsp_amount <= AMOUNT_FULL, "amount above full")

   `EFKA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_amount), "stalled item changed")

   `EFKA_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "second item taken while busy")

   `EFKA_ASSERT_NOW(a_result_ends_item, $rose(rsp_valid), req_ready && !$past(req_ready), "result without an item at work")

endmodule

bind envelope_follower_knee_amount efka_checker #(
   .AMOUNT_FRAC_BITS (AMOUNT_FRAC_BITS)
) u_efka_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_amount (rsp_chan.amount)
);
